>>> hw/rtl/mbd_pkg.sv
// Shared constants and types for the multi-button debounce block.
`timescale 1ns / 1ps
package mbd_pkg;

  // Width of the pin and result fields.
  localparam int FieldW = 6;
  // Width of the debounce count register and its reset value.
  localparam int CfgW = 16;
  localparam logic [CfgW-1:0] DebounceReset = 16'd20;

  // What one button lane reports for the tick being accepted.
  typedef struct packed {
    logic pressed;
    logic press_event;
  } lane_res_t;

  // One result item as held in the output stage.
  typedef struct packed {
    logic [FieldW-1:0] stable_pressed;
    logic [FieldW-1:0] idle_mask;
    logic [FieldW-1:0] press_events;
  } evt_t;

endpackage

>>> hw/rtl/mbd_ifs.sv
// Valid/ready channel interfaces for the pin ticks and the debounced results.
`timescale 1ns / 1ps
interface mbd_pin_if;
  logic                      valid;
  logic                      ready;
  logic [mbd_pkg::FieldW-1:0] pin_levels;

  modport source (output valid, output pin_levels, input ready);
  modport sink (input valid, input pin_levels, output ready);
endinterface

interface mbd_evt_if;
  logic                      valid;
  logic                      ready;
  logic [mbd_pkg::FieldW-1:0] stable_pressed;
  logic [mbd_pkg::FieldW-1:0] idle_mask;
  logic [mbd_pkg::FieldW-1:0] press_events;

  modport source (output valid, output stable_pressed, output idle_mask,
                  output press_events, input ready);
  modport sink (input valid, input stable_pressed, input idle_mask,
                input press_events, output ready);
endinterface

>>> hw/rtl/mbd_lane.sv
// One button lane: four-phase debouncer with saturating tick counter.
`timescale 1ns / 1ps
module mbd_lane #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      pin_low_i,
  input  logic [mbd_pkg::CfgW-1:0]  debounce_i,
  output mbd_pkg::lane_res_t        res_o
);
  import mbd_pkg::*;

  localparam logic [1:0] PhIdle        = 2'd0;
  localparam logic [1:0] PhPressWait   = 2'd1;
  localparam logic [1:0] PhPressed     = 2'd2;
  localparam logic [1:0] PhReleaseWait = 2'd3;

  localparam int CmpW = (COUNT_WIDTH > CfgW) ? COUNT_WIDTH : CfgW;
  localparam logic [COUNT_WIDTH-1:0] CntMax = '1;

  logic [1:0]             phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] elapsed_q, elapsed_d;
  logic                   stable_q, stable_d;
  logic                   sent_q, sent_d;
  logic [COUNT_WIDTH-1:0] elapsed_inc;
  logic                   wait_done;

  // Saturating increment and the end-of-wait test.
  assign elapsed_inc = (elapsed_q == CntMax) ? elapsed_q
                                             : elapsed_q + COUNT_WIDTH'(1);
  assign wait_done = (CmpW'(elapsed_inc) >= CmpW'(debounce_i)) ||
                     (elapsed_inc == CntMax);

  // Phase transitions for one tick.
  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    stable_d  = stable_q;
    unique case (phase_q)
      PhIdle: begin
        if (pin_low_i) begin
          phase_d   = PhPressWait;
          elapsed_d = '0;
        end
      end
      PhPressWait: begin
        elapsed_d = elapsed_inc;
        if (wait_done) begin
          phase_d  = pin_low_i ? PhPressed : PhIdle;
          stable_d = pin_low_i;
        end
      end
      PhPressed: begin
        if (!pin_low_i) begin
          phase_d   = PhReleaseWait;
          elapsed_d = '0;
        end
      end
      PhReleaseWait: begin
        elapsed_d = elapsed_inc;
        if (wait_done) begin
          if (pin_low_i) begin
            phase_d = PhPressed;
          end else begin
            phase_d  = PhIdle;
            stable_d = 1'b0;
          end
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
  end

  // The event fires once per rise of the stable state.
  assign sent_d = stable_d;
  assign res_o.pressed     = stable_d;
  assign res_o.press_event = stable_d & ~sent_q;

  // Lane state advances only on an accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      elapsed_q <= '0;
      stable_q  <= 1'b0;
      sent_q    <= 1'b0;
    end else if (adv_i) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      stable_q  <= stable_d;
      sent_q    <= sent_d;
    end
  end

  // The stable flag is set exactly in the pressed and release-pending phases.
  a_stable_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stable_q == phase_q[1])
    else $error("stable flag disagrees with phase");

  // The sent mark tracks the stable flag from one tick to the next.
  a_sent_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sent_q == stable_q)
    else $error("event mark out of step with stable flag");

endmodule

>>> hw/rtl/mbd_merge.sv
// Merges the lane results into result fields and holds them in a two-entry output stage.
`timescale 1ns / 1ps
module mbd_merge #(
  parameter int BUTTONS = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mbd_pkg::lane_res_t  lanes_i [BUTTONS],
  output logic                ready_o,
  mbd_evt_if.source           evt_o
);
  import mbd_pkg::*;

  logic [FieldW-1:0] pressed_w;
  logic [FieldW-1:0] events_w;
  evt_t              item_w;
  evt_t              out_q;
  evt_t              skid_q;
  logic              out_valid_q;
  logic              skid_valid_q;
  logic              pop;

  // Gather the visible buttons; absent ones read as released.
  for (genvar i = 0; i < FieldW; i++) begin : g_field
    if (i < BUTTONS) begin : g_lane
      assign pressed_w[i] = lanes_i[i].pressed;
      assign events_w[i]  = lanes_i[i].press_event;
    end else begin : g_none
      assign pressed_w[i] = 1'b0;
      assign events_w[i]  = 1'b0;
    end
  end

  assign item_w.stable_pressed = pressed_w;
  assign item_w.idle_mask      = ~pressed_w;
  assign item_w.press_events   = events_w;

  assign pop     = out_valid_q & evt_o.ready;
  assign ready_o = ~skid_valid_q;

  // Output register plus skid entry, so a new tick is taken while a result waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_q <= item_w;
      end else begin
        out_q <= item_w;
      end
    end
  end

  assign evt_o.valid          = out_valid_q;
  assign evt_o.stable_pressed = out_q.stable_pressed;
  assign evt_o.idle_mask      = out_q.idle_mask;
  assign evt_o.press_events   = out_q.press_events;

  // The skid entry is only used behind a held output.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry filled while output register is empty");

  // A press event is only reported for a button shown as pressed.
  a_event_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.press_events & ~out_q.stable_pressed) == '0))
    else $error("press event without stable press");

endmodule

>>> hw/rtl/multi_button_debounce_press_events_unit.sv
// Top level: debounce count register, per-button lanes and the result merge.
//
//   Channel  Direction  Handshake      Payload
//   pin_i    in         valid / ready  pin_levels
//   evt_o    out        valid / ready  stable_pressed, idle_mask, press_events
//   cfg      in         cfg_we_i       cfg_wdata_i (debounce count)
//
// One tick is accepted per cycle while input ready is high; its result is registered in the output stage.
// All button lanes update in parallel in the cycle of the transfer.
// A two-entry output stage keeps input ready high while one result waits;
// ready drops only when both entries are full.
// Reset clears every lane to idle and loads the debounce count with 20.
`timescale 1ns / 1ps
module multi_button_debounce_press_events_unit #(
  parameter int BUTTONS     = 6,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mbd_pkg::CfgW-1:0]  cfg_wdata_i,
  mbd_pin_if.sink                   pin_i,
  mbd_evt_if.source                 evt_o
);
  import mbd_pkg::*;

  logic [CfgW-1:0] debounce_q;
  logic            accept;
  logic            merge_ready;
  lane_res_t       lane_res [BUTTONS];

  // Debounce count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceReset;
    end else if (cfg_we_i) begin
      debounce_q <= cfg_wdata_i;
    end
  end

  assign pin_i.ready = merge_ready;
  assign accept      = pin_i.valid & merge_ready;

  // One debouncer lane per button; pins beyond the field read as released.
  for (genvar b = 0; b < BUTTONS; b++) begin : g_lane
    logic pin_low;
    if (b < FieldW) begin : g_pin
      assign pin_low = ~pin_i.pin_levels[b];
    end else begin : g_nopin
      assign pin_low = 1'b0;
    end

    mbd_lane #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (accept),
      .pin_low_i  (pin_low),
      .debounce_i (debounce_q),
      .res_o      (lane_res[b])
    );
  end

  // Combine lane results and buffer the result transfer.
  mbd_merge #(
    .BUTTONS (BUTTONS)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .lanes_i (lane_res),
    .ready_o (merge_ready),
    .evt_o   (evt_o)
  );

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the six-button debouncer with one-shot press events.
`timescale 1ns / 1ps
module tb_top;
  import mbd_pkg::*;

  localparam int ClkPeriod  = 10;
  localparam int CountW     = 16;
  localparam int PlanRows   = 25;
  localparam int NumPhases  = 9;
  localparam int PhaseTicks = 105;
  localparam int HoldCycles = 60;
  localparam int ReportMax  = 10;
  localparam int CycleLimit = 200000;

  // Debouncer phases of one button lane.
  typedef enum logic [1:0] {
    LANE_IDLE      = 2'd0,
    LANE_ARMING    = 2'd1,
    LANE_HELD      = 2'd2,
    LANE_RELEASING = 2'd3
  } lane_phase_e;

  // Kinds of rows in the directed plan.
  typedef enum logic {
    ROW_TICK = 1'b0,
    ROW_LEN  = 1'b1
  } row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [FieldW-1:0] pins;
    logic              literal_exp;
    evt_t              want;
    logic [CfgW-1:0]   len;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgW-1:0] cfg_wdata_i;

  mbd_pin_if pin_if ();
  mbd_evt_if evt_if ();

  multi_button_debounce_press_events_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pin_i       (pin_if),
    .evt_o       (evt_if)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Shadow copy of the debouncer state and the debounce count.
  logic [CfgW-1:0]   debounce_len;
  lane_phase_e       lane_phase [FieldW];
  logic [CountW-1:0] lane_count [FieldW];
  logic [FieldW-1:0] lane_down;
  logic [FieldW-1:0] lane_reported;

  // Results still owed by the block, oldest first.
  evt_t pending_results [$];

  // A directed row may carry a literal expectation instead of the predicted one.
  logic              row_literal;
  evt_t              row_want;
  logic [FieldW-1:0] held_levels;

  logic hold_req;
  logic steady;

  int cycle_cnt;
  int fault_cnt;
  int ticks_accepted;
  int results_checked;
  int press_events_seen;
  int len_writes;
  int holds_done;

  // Advance the shadow debouncer by one tick and return the result it produces.
  function automatic evt_t debounce_tick(input logic [FieldW-1:0] pins);
    evt_t res;
    logic pin_low;
    res = '0;
    for (int b = 0; b < FieldW; b++) begin
      pin_low = ~pins[b];
      case (lane_phase[b])
        LANE_IDLE: begin
          if (pin_low) begin
            lane_phase[b] = LANE_ARMING;
            lane_count[b] = '0;
          end
        end
        LANE_HELD: begin
          if (!pin_low) begin
            lane_phase[b] = LANE_RELEASING;
            lane_count[b] = '0;
          end
        end
        default: begin
          // Pending lanes count first, then resolve on the sampled level.
          if (lane_count[b] != '1) lane_count[b] = lane_count[b] + 1'b1;
          if (lane_count[b] >= debounce_len || lane_count[b] == '1) begin
            if (lane_phase[b] == LANE_ARMING) begin
              lane_phase[b] = pin_low ? LANE_HELD : LANE_IDLE;
              lane_down[b]  = pin_low;
            end else if (pin_low) begin
              lane_phase[b] = LANE_HELD;
            end else begin
              lane_phase[b] = LANE_IDLE;
              lane_down[b]  = 1'b0;
            end
          end
        end
      endcase
      // A press event fires once per rise of the stable state.
      if (lane_down[b]) begin
        res.press_events[b]   = ~lane_reported[b];
        res.stable_pressed[b] = 1'b1;
        lane_reported[b]      = 1'b1;
      end else begin
        lane_reported[b] = 1'b0;
      end
    end
    res.idle_mask = ~res.stable_pressed;
    return res;
  endfunction

  function automatic plan_row_t pin_row(input logic [FieldW-1:0] pins);
    return '{ROW_TICK, pins, 1'b0, '0, '0};
  endfunction

  function automatic plan_row_t pin_row_fixed(input logic [FieldW-1:0] pins,
                                              input logic [FieldW-1:0] sp,
                                              input logic [FieldW-1:0] im,
                                              input logic [FieldW-1:0] pe);
    evt_t want;
    want.stable_pressed = sp;
    want.idle_mask      = im;
    want.press_events   = pe;
    return '{ROW_TICK, pins, 1'b1, want, '0};
  endfunction

  function automatic plan_row_t len_row(input logic [CfgW-1:0] len);
    return '{ROW_LEN, '1, 1'b0, '0, len};
  endfunction

  // Button-like levels: held per button, flipped now and then, with contact bounce
  // and a share of plain noise.
  function automatic logic [FieldW-1:0] next_pins();
    logic [FieldW-1:0] bounce;
    for (int b = 0; b < FieldW; b++) begin
      if ($urandom_range(99) < 6) held_levels[b] = ~held_levels[b];
    end
    if ($urandom_range(99) < 10) return FieldW'($urandom_range(63));
    bounce = '0;
    if ($urandom_range(99) < 20) begin
      bounce = FieldW'($urandom_range(63)) & FieldW'($urandom_range(63));
    end
    return held_levels ^ bounce;
  endfunction

  // Offer one tick, with random gaps, and return after its transfer.
  task automatic send_tick(input logic [FieldW-1:0] pins);
    if (!steady) begin
      while ($urandom_range(99) < 18) begin
        pin_if.valid = 1'b0;
        @(negedge clk_i);
      end
    end
    pin_if.valid      = 1'b1;
    pin_if.pin_levels = pins;
    do @(posedge clk_i); while (!pin_if.ready);
    @(negedge clk_i);
  endtask

  // Stop offering ticks and wait until every owed result has arrived.
  task automatic drain();
    pin_if.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // Write the debounce count while the block is idle.
  task automatic write_debounce(input logic [CfgW-1:0] len);
    drain();
    repeat (2) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = len;
    @(negedge clk_i);
    cfg_we_i     = 1'b0;
    debounce_len = len;
    len_writes++;
  endtask

  // Predict on each input transfer and check each result transfer.
  always @(posedge clk_i) begin
    evt_t want;
    evt_t got;
    cycle_cnt++;
    if (rst_ni) begin
      if (pin_if.valid && pin_if.ready) begin
        want = debounce_tick(pin_if.pin_levels);
        if (row_literal) want = row_want;
        pending_results.push_back(want);
        ticks_accepted++;
      end
      if (evt_if.valid && evt_if.ready) begin
        got.stable_pressed = evt_if.stable_pressed;
        got.idle_mask      = evt_if.idle_mask;
        got.press_events   = evt_if.press_events;
        if (pending_results.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= ReportMax) begin
            $display("[%0t] unexpected result: pressed=%h idle=%h events=%h",
                     $realtime, got.stable_pressed, got.idle_mask, got.press_events);
          end
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          press_events_seen += $countones(got.press_events);
          if (got.stable_pressed !== want.stable_pressed ||
              got.idle_mask !== want.idle_mask ||
              got.press_events !== want.press_events) begin
            fault_cnt++;
            if (fault_cnt <= ReportMax) begin
              $display("[%0t] result %0d mismatch: pressed exp %h got %h, idle exp %h got %h,",
                       $realtime, results_checked, want.stable_pressed, got.stable_pressed,
                       want.idle_mask, got.idle_mask);
              $display("    events exp %h got %h", want.press_events, got.press_events);
            end
          end
        end
      end
    end
  end

  // Result side: random back-pressure, one long hold-off on request.
  initial begin
    evt_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        evt_if.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
        holds_done++;
      end
      evt_if.ready = steady || ($urandom_range(99) >= 18);
    end
  end

  // Watchdog on the cycle count.
  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("TEST FAILED");
    $finish;
  end

  // Reset, directed plan, then random phases over several debounce counts.
  initial begin
    plan_row_t plan [PlanRows];
    logic [CfgW-1:0] phase_len [NumPhases];
    logic [CfgW-1:0] len;
    int items;

    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    pin_if.valid      = 1'b0;
    pin_if.pin_levels = '1;
    row_literal       = 1'b0;
    row_want          = '0;
    held_levels       = '1;
    hold_req          = 1'b0;
    steady            = 1'b0;
    cycle_cnt         = 0;
    fault_cnt         = 0;
    ticks_accepted    = 0;
    results_checked   = 0;
    press_events_seen = 0;
    len_writes        = 0;
    holds_done        = 0;

    // Shadow state after reset: every lane idle, count at its reset value.
    debounce_len  = DebounceReset;
    lane_down     = '0;
    lane_reported = '0;
    for (int b = 0; b < FieldW; b++) begin
      lane_phase[b] = LANE_IDLE;
      lane_count[b] = '0;
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset count first, then a zero count that behaves as one, then bounce
    // on press and release, and finally the largest count.
    plan = '{
      pin_row_fixed(6'h3F, 6'h00, 6'h3F, 6'h00),
      pin_row_fixed(6'h00, 6'h00, 6'h3F, 6'h00),
      pin_row_fixed(6'h00, 6'h00, 6'h3F, 6'h00),
      len_row(16'd0),
      pin_row_fixed(6'h00, 6'h3F, 6'h00, 6'h3F),
      pin_row_fixed(6'h00, 6'h3F, 6'h00, 6'h00),
      pin_row_fixed(6'h3F, 6'h3F, 6'h00, 6'h00),
      pin_row_fixed(6'h3F, 6'h00, 6'h3F, 6'h00),
      len_row(16'd1),
      pin_row(6'h2A),
      pin_row(6'h15),
      pin_row(6'h15),
      pin_row(6'h3F),
      pin_row(6'h00),
      len_row(16'd3),
      pin_row(6'h3E),
      pin_row(6'h3F),
      pin_row(6'h3E),
      pin_row(6'h3E),
      pin_row(6'h3F),
      len_row(16'hFFFF),
      pin_row(6'h00),
      pin_row(6'h00),
      pin_row(6'h1F),
      pin_row(6'h3F)
    };
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_LEN) begin
        write_debounce(plan[i].len);
      end else begin
        row_literal = plan[i].literal_exp;
        row_want    = plan[i].want;
        send_tick(plan[i].pins);
      end
    end
    row_literal = 1'b0;

    // Random phases: phase 1 holds the result side off, phase 2 runs without
    // gaps, phase 3 pauses the sender halfway until all results are back.
    phase_len = '{16'd2, 16'd5, 16'd1, 16'd4, 16'd0, 16'hFFFF, 16'd3, 16'd20, 16'd0};
    for (int ph = 0; ph < NumPhases; ph++) begin
      len = (ph == NumPhases - 1) ? CfgW'($urandom_range(1, 12)) : phase_len[ph];
      write_debounce(len);
      hold_req = (ph == 1);
      steady   = (ph == 2);
      items    = (len == 16'hFFFF) ? 40 : PhaseTicks;
      for (int n = 0; n < items; n++) begin
        if (ph == 3 && n == items / 2) drain();
        send_tick(next_pins());
      end
    end
    steady = 1'b0;
    drain();
    repeat (8) @(posedge clk_i);

    if (pending_results.size() != 0) begin
      $display("%0d results never arrived", pending_results.size());
      fault_cnt += pending_results.size();
    end

    $display("Ran %0d ticks through %0d debounce settings, %0d results checked.",
             ticks_accepted, len_writes, results_checked);
    $display("Saw %0d press events, %0d long result hold-offs, %0d failures.",
             press_events_seen, holds_done, fault_cnt);
    if (fault_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
